/* rtl/core/sitd_pkg.sv */
// ----------------------------------------------------------------------------
// sitd_pkg: shared types and constants for the signed integer to ascii block
// Character codes, BCD geometry, the sequencer state type and digit helpers.
// ----------------------------------------------------------------------------
package sitd_pkg;

    // input and output widths
    localparam int VALUE_W   = 32;
    localparam int CHAR_W    = 8;

    // bcd geometry: ten digits cover the full 32-bit unsigned magnitude
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int CNT_W      = $clog2(VALUE_W);

    // ascii codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // shift-add-3 correction
    localparam logic [DIGIT_W-1:0] ADJ_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] ADJ_ADD   = 4'd3;

    // top level sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    // pick one digit out of the packed bcd word
    function automatic logic [DIGIT_W-1:0] get_digit(input logic [BCD_W-1:0] bcd,
                                                     input logic [IDX_W-1:0] idx);
        logic [DIGIT_W-1:0] d;
        d = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (idx == IDX_W'(i)) begin
                d = bcd[i*DIGIT_W +: DIGIT_W];
            end
        end
        return d;
    endfunction

    // index of the most significant nonzero digit, zero when all digits are zero
    function automatic logic [IDX_W-1:0] lead_digit(input logic [BCD_W-1:0] bcd);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/core/sitd_bcd.sv */
// ----------------------------------------------------------------------------
// sitd_bcd: iterative binary to bcd converter
// Shift-add-3 over one magnitude bit per cycle, across all 32 magnitude bits.
// ----------------------------------------------------------------------------
module sitd_bcd (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sitd_pkg::VALUE_W-1:0]  i_mag,
    output logic                          o_done,
    output logic [sitd_pkg::BCD_W-1:0]    o_bcd
);
    import sitd_pkg::*;

    logic [VALUE_W-1:0] r_shift, n_shift;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [BCD_W-1:0]   adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[i*DIGIT_W +: DIGIT_W] >= ADJ_LIMIT) begin
                adj[i*DIGIT_W +: DIGIT_W] = r_bcd[i*DIGIT_W +: DIGIT_W] + ADJ_ADD;
            end else begin
                adj[i*DIGIT_W +: DIGIT_W] = r_bcd[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // iteration control
    always_comb begin
        n_shift = r_shift;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_shift = i_mag;
            n_bcd   = '0;
            n_cnt   = '0;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_bcd   = {adj[BCD_W-2:0], r_shift[VALUE_W-1]};
            n_shift = {r_shift[VALUE_W-2:0], 1'b0};
            n_cnt   = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

/* rtl/core/signed_int_to_decimal_ascii_top.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top: signed 32-bit integer to decimal ascii text
// Emits an optional minus sign and the digits, most significant first.
// ----------------------------------------------------------------------------
// sequence: after the input transfer the bcd unit runs its shift-add-3
//   iterations and registers done, then the sequencer enters emission
// output: n = 1..11 characters per item, one per cycle when the output is ready;
//   a new item is taken only after the last character of the one before
// reset: synchronous active low, clears the sequencer and the bcd unit control
module signed_int_to_decimal_ascii_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input stream
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic signed [31:0]  i_s_tdata,   // [31:0] value
    // output stream
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [7:0]          o_m_tdata,   // [7:0] ascii_char
    output logic                o_m_tlast    // last_char
);
    import sitd_pkg::*;

    t_state             r_state, n_state;
    logic               r_neg, n_neg;
    logic               r_sign, n_sign;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               start;
    logic               done;
    logic [VALUE_W-1:0] mag;
    logic [BCD_W-1:0]   bcd;
    logic               out_xfer;

    // magnitude as a full unsigned value
    assign mag = i_s_tdata[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(i_s_tdata))
                                      : VALUE_W'(i_s_tdata);

    sitd_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mag   (mag),
        .o_done  (done),
        .o_bcd   (bcd)
    );

    // handshake outputs
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = (r_state == ST_EMIT);
    assign start      = i_s_tvalid && o_s_tready;
    assign out_xfer   = o_m_tvalid && i_m_tready;

    // current character
    always_comb begin
        if (r_sign) begin
            o_m_tdata = CHAR_MINUS;
            o_m_tlast = 1'b0;
        end else begin
            o_m_tdata = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, get_digit(bcd, r_idx)};
            o_m_tlast = (r_idx == '0);
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        n_sign  = r_sign;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_neg   = i_s_tdata[VALUE_W-1];
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (done) begin
                    n_idx   = lead_digit(bcd);
                    n_sign  = r_neg;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_xfer) begin
                    if (r_sign) begin
                        n_sign = 1'b0;
                    end else if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sign  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_sign  <= n_sign;
            r_idx   <= n_idx;
        end
    end

    // sign of the item in flight
    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
    end

endmodule
